@@ design/ptp_pkg.sv @@
package ptp_pkg;

  // field widths
  localparam int COORD_W    = 16;
  localparam int PIXEL_W    = 12;
  localparam int CF_W       = 16;
  localparam int FRAC_W     = 14;
  localparam int CAM_W      = 16;
  localparam int CAM_FRAC   = 4;

  // configuration register widths
  localparam int ROW_W      = 3 * CF_W;
  localparam int FOC_W      = 2 * CAM_W;
  localparam int SIZE_W     = 2 * PIXEL_W;
  localparam int CFG_DATA_W = ROW_W;
  localparam int CFG_IDX_W  = 3;

  // datapath widths
  localparam int PROD_W     = CF_W + COORD_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int RND_W      = ACC_W - FRAC_W;
  localparam int PP_W       = COORD_W + CAM_W + 1;
  localparam int NUM_W      = PP_W + 1;
  localparam int MAG_W      = NUM_W - 1;
  localparam int DEN_W      = COORD_W + CAM_FRAC;
  localparam int REM_W      = DEN_W + PIXEL_W;
  localparam int ROUND_HALF = 1 << (FRAC_W - 1);

  // pipeline stage positions
  localparam int ST_PROD    = 0;
  localparam int ST_ACC     = 1;
  localparam int ST_MOVE    = 2;
  localparam int ST_PPROD   = 3;
  localparam int ST_NUM     = 4;
  localparam int ST_ABS     = 5;
  localparam int ST_DIV0    = 6;
  localparam int ST_OUT     = ST_DIV0 + PIXEL_W;
  localparam int NUM_ST     = ST_OUT + 1;

  // register reset values
  localparam logic [ROW_W-1:0]  ROT0_RST  = ROW_W'(48'h4000_0000_0000);
  localparam logic [ROW_W-1:0]  ROT1_RST  = ROW_W'(48'h0000_4000_0000);
  localparam logic [ROW_W-1:0]  ROT2_RST  = ROW_W'(48'h0000_0000_4000);
  localparam logic [ROW_W-1:0]  TRANS_RST = '0;
  localparam logic [FOC_W-1:0]  FOCAL_RST = FOC_W'(32'h2113_20D9);
  localparam logic [FOC_W-1:0]  PPT_RST   = FOC_W'(32'h148F_10B8);
  localparam logic [SIZE_W-1:0] SIZE_RST  = SIZE_W'(24'h280_1E0);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT0,
    REG_ROT1,
    REG_ROT2,
    REG_TRANS,
    REG_FOCAL,
    REG_PPT,
    REG_SIZE
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } moved_t;

  // clamp a rounded coordinate into the output range
  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [RND_W-1:0] v);
    logic [RND_W-COORD_W:0] upper;
    logic signed [COORD_W-1:0] res;
    upper = v[RND_W-1:COORD_W-1];
    if ((&upper) || !(|upper)) begin
      res = v[COORD_W-1:0];
    end else if (v[RND_W-1]) begin
      res = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

@@ design/ptp_in_if.sv @@
interface ptp_in_if;
  import ptp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

@@ design/ptp_out_if.sv @@
interface ptp_out_if;
  import ptp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] moved_x;
  logic signed [COORD_W-1:0] moved_y;
  logic signed [COORD_W-1:0] moved_z;
  logic [PIXEL_W-1:0]        pixel_u;
  logic [PIXEL_W-1:0]        pixel_v;

  modport source (output valid, output moved_x, output moved_y, output moved_z,
                  output pixel_u, output pixel_v, input ready);
  modport sink   (input valid, input moved_x, input moved_y, input moved_z,
                  input pixel_u, input pixel_v, output ready);
endinterface

@@ design/ptp_div.sv @@
module ptp_div (
  input  logic                         clk,
  input  logic [ptp_pkg::PIXEL_W-1:0]  ld,
  input  logic [ptp_pkg::REM_W-1:0]    num,
  input  logic [ptp_pkg::DEN_W-1:0]    den,
  output logic [ptp_pkg::PIXEL_W-1:0]  quo
);
  import ptp_pkg::*;

  localparam int DIV_N = PIXEL_W;

  logic [REM_W-1:0]   rem_in [DIV_N];
  logic [DEN_W-1:0]   den_in [DIV_N];
  logic [PIXEL_W-1:0] quo_in [DIV_N];
  logic [PIXEL_W-1:0] quo_r  [DIV_N];
  logic [REM_W-1:0]   rem_r  [DIV_N-1];
  logic [DEN_W-1:0]   den_r  [DIV_N-1];

  // first step takes the operands straight from the previous stage
  assign rem_in[0] = num;
  assign den_in[0] = den;
  assign quo_in[0] = '0;

  for (genvar j = 1; j < DIV_N; j++) begin : g_link
    assign rem_in[j] = rem_r[j-1];
    assign den_in[j] = den_r[j-1];
    assign quo_in[j] = quo_r[j-1];
  end

  // one restoring step per stage, most significant quotient bit first
  for (genvar j = 0; j < DIV_N; j++) begin : g_step
    localparam int K = DIV_N - 1 - j;
    logic [REM_W-1:0] sub;
    logic             geq;

    assign sub = REM_W'(den_in[j]) << K;
    assign geq = rem_in[j] >= sub;

    always_ff @(posedge clk) begin
      if (ld[j]) begin
        quo_r[j] <= quo_in[j] | (PIXEL_W'(geq) << K);
      end
    end

    if (j < DIV_N - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (ld[j]) begin
          rem_r[j] <= geq ? rem_in[j] - sub : rem_in[j];
          den_r[j] <= den_in[j];
        end
      end
    end
  end

  assign quo = quo_r[DIV_N-1];

endmodule

@@ design/point_transform_project_top.sv @@
// rigid transform and pinhole projection of depth points, 19-stage pipeline
// throughput: one point per cycle; every stage holds its request under a stall
// and bubbles close up, so the input only stops when all stages are full
// reset (synchronous, rst_n low) empties the pipeline and loads the default
// identity transform, camera intrinsics and 640x480 image size
module point_transform_project_top (
  input  logic                              clk,
  input  logic                              rst_n,
  ptp_in_if.sink                            in_pt,
  ptp_out_if.source                         out_res,
  input  logic                              cfg_we,
  input  logic [ptp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ptp_pkg::*;

  // configuration registers
  logic [ROW_W-1:0]  rot_r [3];
  logic [ROW_W-1:0]  trans_r;
  logic [FOC_W-1:0]  focal_r;
  logic [FOC_W-1:0]  ppt_r;
  logic [SIZE_W-1:0] size_r;

  // pipeline control
  logic [NUM_ST-1:0] v_r;
  logic [NUM_ST-1:0] rdy;
  logic [NUM_ST-1:0] vin;
  logic [NUM_ST-1:0] ld;
  logic              pass;

  // datapath
  logic signed [COORD_W-1:0] pin [3];
  logic signed [PROD_W-1:0]  prod_r [3][3];
  logic signed [PROD_W-1:0]  prod_nxt [3][3];
  logic signed [ACC_W-1:0]   acc_r [3];
  logic signed [ACC_W-1:0]   acc_nxt [3];
  moved_t                    mv_r [ST_MOVE:ST_OUT-1];
  moved_t                    mv_nxt;
  logic signed [PP_W-1:0]    pprod_r [4];
  logic signed [PP_W-1:0]    pprod_nxt [4];
  logic signed [NUM_W-1:0]   num_r [2];
  logic signed [NUM_W-1:0]   num_nxt [2];
  logic [MAG_W-1:0]          nabs_r [2];
  logic [MAG_W-1:0]          nabs_nxt [2];
  logic [DEN_W-1:0]          den_r;
  logic [DEN_W-1:0]          den_nxt;
  logic [1:0]                sok_r;
  logic [1:0]                sok_nxt;
  logic [1:0]                okf_r [ST_DIV0:ST_OUT-1];
  logic [1:0]                okf_nxt;
  logic [PIXEL_W-1:0]        qu;
  logic [PIXEL_W-1:0]        qv;
  moved_t                    out_mv_r;
  logic [PIXEL_W-1:0]        out_u_r;
  logic [PIXEL_W-1:0]        out_v_r;

  // register writes, out-of-range index ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0] <= ROT0_RST;
      rot_r[1] <= ROT1_RST;
      rot_r[2] <= ROT2_RST;
      trans_r  <= TRANS_RST;
      focal_r  <= FOCAL_RST;
      ppt_r    <= PPT_RST;
      size_r   <= SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROT0:  rot_r[0] <= cfg_data[ROW_W-1:0];
        REG_ROT1:  rot_r[1] <= cfg_data[ROW_W-1:0];
        REG_ROT2:  rot_r[2] <= cfg_data[ROW_W-1:0];
        REG_TRANS: trans_r  <= cfg_data[ROW_W-1:0];
        REG_FOCAL: focal_r  <= cfg_data[FOC_W-1:0];
        REG_PPT:   ppt_r    <= cfg_data[FOC_W-1:0];
        REG_SIZE:  size_r   <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage can take a request when the output is ready or it or any stage after it is empty
  always_comb begin
    for (int s = 0; s < NUM_ST; s++) begin
      rdy[s] = out_res.ready || (((~v_r) >> s) != '0);
    end
    vin[0] = in_pt.valid;
    for (int s = 1; s < NUM_ST; s++) begin
      vin[s] = v_r[s-1];
    end
    ld = rdy & vin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < ST_OUT; s++) begin
        if (rdy[s]) begin
          v_r[s] <= vin[s];
        end
      end
      if (rdy[ST_OUT]) begin
        v_r[ST_OUT] <= vin[ST_OUT] && pass;
      end
    end
  end

  // rotation products
  always_comb begin
    pin[0] = in_pt.point_x;
    pin[1] = in_pt.point_y;
    pin[2] = in_pt.point_z;
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        prod_nxt[a][k] = $signed(rot_r[a][CF_W*(2-k) +: CF_W]) * pin[k];
      end
    end
  end

  // row sums plus translation and rounding offset
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      acc_nxt[a] = ACC_W'(prod_r[a][0]) + ACC_W'(prod_r[a][1]) + ACC_W'(prod_r[a][2])
                 + (ACC_W'($signed(trans_r[CF_W*(2-a) +: CF_W])) <<< FRAC_W)
                 + ACC_W'(ROUND_HALF);
    end
  end

  // drop the fraction and clamp to the coordinate range
  always_comb begin
    mv_nxt.x = sat_coord(RND_W'(acc_r[0] >>> FRAC_W));
    mv_nxt.y = sat_coord(RND_W'(acc_r[1] >>> FRAC_W));
    mv_nxt.z = sat_coord(RND_W'(acc_r[2] >>> FRAC_W));
  end

  // projection products: x*fx, cx*z, y*fy, cy*z
  always_comb begin
    pprod_nxt[0] = mv_r[ST_MOVE].x * $signed({1'b0, focal_r[FOC_W-1 -: CAM_W]});
    pprod_nxt[1] = mv_r[ST_MOVE].z * $signed({1'b0, ppt_r[FOC_W-1 -: CAM_W]});
    pprod_nxt[2] = mv_r[ST_MOVE].y * $signed({1'b0, focal_r[CAM_W-1:0]});
    pprod_nxt[3] = mv_r[ST_MOVE].z * $signed({1'b0, ppt_r[CAM_W-1:0]});
  end

  // numerators
  always_comb begin
    num_nxt[0] = NUM_W'(pprod_r[0]) + NUM_W'(pprod_r[1]);
    num_nxt[1] = NUM_W'(pprod_r[2]) + NUM_W'(pprod_r[3]);
  end

  // magnitudes; a positive quotient needs equal signs and a nonzero numerator
  always_comb begin
    logic [COORD_W-1:0] zabs;
    logic               zneg;
    zneg = mv_r[ST_NUM].z[COORD_W-1];
    zabs = zneg ? COORD_W'(-mv_r[ST_NUM].z) : COORD_W'(mv_r[ST_NUM].z);
    den_nxt = {zabs, {CAM_FRAC{1'b0}}};
    for (int i = 0; i < 2; i++) begin
      nabs_nxt[i] = num_r[i][NUM_W-1] ? MAG_W'(-num_r[i]) : MAG_W'(num_r[i]);
      sok_nxt[i]  = (num_r[i][NUM_W-1] == zneg) && (num_r[i] != '0);
    end
  end

  // quotient too large for the pixel range; also catches a zero depth
  always_comb begin
    logic [MAG_W-1:0] lim;
    lim = MAG_W'({den_r, {PIXEL_W{1'b0}}});
    for (int i = 0; i < 2; i++) begin
      okf_nxt[i] = sok_r[i] && (nabs_r[i] < lim);
    end
  end

  ptp_div u_div_u (
    .clk (clk),
    .ld  (ld[ST_OUT-1:ST_DIV0]),
    .num (nabs_r[0][REM_W-1:0]),
    .den (den_r),
    .quo (qu)
  );

  ptp_div u_div_v (
    .clk (clk),
    .ld  (ld[ST_OUT-1:ST_DIV0]),
    .num (nabs_r[1][REM_W-1:0]),
    .den (den_r),
    .quo (qv)
  );

  // pixel must land strictly inside the image
  assign pass = okf_r[ST_OUT-1][0] && okf_r[ST_OUT-1][1]
             && (qu != '0) && (qu < size_r[SIZE_W-1 -: PIXEL_W])
             && (qv != '0) && (qv < size_r[PIXEL_W-1:0]);

  // payload registers
  always_ff @(posedge clk) begin
    if (ld[ST_PROD]) begin
      prod_r <= prod_nxt;
    end
    if (ld[ST_ACC]) begin
      acc_r <= acc_nxt;
    end
    if (ld[ST_MOVE]) begin
      mv_r[ST_MOVE] <= mv_nxt;
    end
    for (int s = ST_MOVE + 1; s < ST_OUT; s++) begin
      if (ld[s]) begin
        mv_r[s] <= mv_r[s-1];
      end
    end
    if (ld[ST_PPROD]) begin
      pprod_r <= pprod_nxt;
    end
    if (ld[ST_NUM]) begin
      num_r <= num_nxt;
    end
    if (ld[ST_ABS]) begin
      nabs_r <= nabs_nxt;
      den_r  <= den_nxt;
      sok_r  <= sok_nxt;
    end
    if (ld[ST_DIV0]) begin
      okf_r[ST_DIV0] <= okf_nxt;
    end
    for (int s = ST_DIV0 + 1; s < ST_OUT; s++) begin
      if (ld[s]) begin
        okf_r[s] <= okf_r[s-1];
      end
    end
    if (ld[ST_OUT]) begin
      out_mv_r <= mv_r[ST_OUT-1];
      out_u_r  <= qu;
      out_v_r  <= qv;
    end
  end

  // ports
  assign in_pt.ready     = rdy[ST_PROD];
  assign out_res.valid   = v_r[ST_OUT];
  assign out_res.moved_x = out_mv_r.x;
  assign out_res.moved_y = out_mv_r.y;
  assign out_res.moved_z = out_mv_r.z;
  assign out_res.pixel_u = out_u_r;
  assign out_res.pixel_v = out_v_r;

endmodule

@@ design/ptp_checker.sv @@
module ptp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [ptp_pkg::COORD_W-1:0] out_moved_z,
  input logic [ptp_pkg::PIXEL_W-1:0]        out_pixel_u,
  input logic [ptp_pkg::PIXEL_W-1:0]        out_pixel_v
);
  import ptp_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel_u) && $stable(out_pixel_v)
                                && $stable(out_moved_z))
    else $error("result payload changed while stalled");

  // results come out only with nonzero pixel coordinates at nonzero depth
  a_out_filter: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel_u != '0) && (out_pixel_v != '0) && (out_moved_z != '0))
    else $error("result outside the image or at zero depth");

  // with the output register empty the pipeline always takes a request
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind point_transform_project_top ptp_checker u_ptp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_pt.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .out_moved_z (out_res.moved_z),
  .out_pixel_u (out_res.pixel_u),
  .out_pixel_v (out_res.pixel_v)
);
